[src/bcdc_pkg.sv]
// ----------------------------------------------------------------------------
// bcdc_pkg
// Types, operation codes and BCD helpers shared by the alarm clock modules.
// ----------------------------------------------------------------------------
package bcdc_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_SET_TIME = 3'd1,
        OP_SET_ALRM = 3'd2,
        OP_CANCEL   = 3'd3,
        OP_DISABLE  = 3'd4,
        OP_ENABLE   = 3'd5,
        OP_SNOOZE   = 3'd6,
        OP_READ     = 3'd7
    } op_t;

    localparam logic [15:0] TICKS_RESET = 16'd1000;
    localparam logic [23:0] LAST_SECOND = 24'h235959;

    typedef struct packed {
        op_t         operation;
        logic [23:0] time_value;
        logic [6:0]  snooze_minutes;
    } item_t;

    typedef struct packed {
        logic        op_ok;
        logic [23:0] current_time;
        logic [23:0] alarm_time;
        logic        time_valid;
        logic        alarm_valid;
        logic        alarm_active;
        logic        alarm_enabled;
        logic        alarm_ringing;
        logic        ring_event;
    } result_t;

    typedef struct packed {
        logic [15:0] tick_count;
        logic [23:0] time_now;
        logic [23:0] alarm_at;
        logic        time_ok;
        logic        alarm_ok;
        logic        armed;
        logic        enabled;
        logic        ringing;
    } state_t;

    // hh:mm:ss digit check, 00:00:00 to 23:59:59
    function automatic logic bcd_valid(input logic [23:0] v);
        logic ok;
        ok = 1'b1;
        if (v[23:20] > 4'd2 || v[19:16] > 4'd9) ok = 1'b0;
        if (v[23:20] == 4'd2 && v[19:16] > 4'd3) ok = 1'b0;
        if (v[15:12] > 4'd5 || v[11:8] > 4'd9) ok = 1'b0;
        if (v[7:4] > 4'd5 || v[3:0] > 4'd9) ok = 1'b0;
        return ok;
    endfunction

    // binary 0..59 to two BCD digits
    function automatic logic [7:0] bin_to_bcd(input logic [5:0] b);
        logic [3:0] tens;
        logic [5:0] rem;
        tens = 4'd0;
        rem  = b;
        if (rem >= 6'd50)
        begin
            tens = 4'd5;
            rem  = rem - 6'd50;
        end
        else if (rem >= 6'd40)
        begin
            tens = 4'd4;
            rem  = rem - 6'd40;
        end
        else if (rem >= 6'd30)
        begin
            tens = 4'd3;
            rem  = rem - 6'd30;
        end
        else if (rem >= 6'd20)
        begin
            tens = 4'd2;
            rem  = rem - 6'd20;
        end
        else if (rem >= 6'd10)
        begin
            tens = 4'd1;
            rem  = rem - 6'd10;
        end
        return {tens, rem[3:0]};
    endfunction

endpackage

[src/bcd_clock_with_alarm_snooze_unit.sv]
// ----------------------------------------------------------------------------
// bcd_clock_with_alarm_snooze_unit
// 24-hour BCD clock with tick prescaler, one alarm and snooze.
// ----------------------------------------------------------------------------
// One beat enters per clock cycle while results are taken: it is captured in
// an input register, then the clock state and result register are updated
// together once the result register is free. Throughput is one beat per cycle
// without result stalls, set by the single state update of the step logic.
// Each beat gives exactly one result. The user must write ticks_per_second
// (APB offset 0x0, reset 1000) only while idle; the unit does not enforce it.
module bcd_clock_with_alarm_snooze_unit
    import bcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        in_v_reg;
    logic        in_v_next;
    item_t       in_reg;
    logic        res_v_reg;
    logic        res_v_next;
    result_t     res_reg;
    result_t     res_next;
    state_t      st_reg;
    state_t      st_next;
    logic [15:0] tps_reg;
    logic        advance;
    logic        cfg_wr;

    assign advance    = in_v_reg && (!res_v_reg || result_ready);
    assign item_ready = !in_v_reg || advance;
    assign in_v_next  = (item_valid && item_ready) || (in_v_reg && !advance);
    assign res_v_next = advance || (res_v_reg && !result_ready);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {16'd0, tps_reg};

    bcdc_step u_step (
        .item             (in_reg),
        .cur              (st_reg),
        .ticks_per_second (tps_reg),
        .nxt              (st_next),
        .res              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
            st_reg    <= '0;
            tps_reg   <= TICKS_RESET;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            res_v_reg <= res_v_next;
            if (advance)
                st_reg <= st_next;
            if (cfg_wr)
                tps_reg <= pwdata[15:0];
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_reg <= item;
        if (advance)
            res_reg <= res_next;
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_ring_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.ring_event |->
            result.alarm_ringing && result.alarm_enabled && result.alarm_active
            && result.op_ok)
        else $error("ring_event without ringing, enabled and armed alarm");

    a_time_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> bcd_valid(result.current_time) && bcd_valid(result.alarm_time))
        else $error("clock or alarm holds an invalid BCD time");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && (!res_v_reg || result_ready) |=> result_valid)
        else $error("captured beat did not reach the result register");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("clock state changed without a beat");
`endif

endmodule

[src/bcdc_step.sv]
// ----------------------------------------------------------------------------
// bcdc_step
// Next-state and result logic for one beat: prescaler, BCD second advance,
// set/validate, alarm actions and snooze arithmetic.
// ----------------------------------------------------------------------------
module bcdc_step
    import bcdc_pkg::*;
(
    input  item_t       item,
    input  state_t      cur,
    input  logic [15:0] ticks_per_second,
    output state_t      nxt,
    output result_t     res
);

    logic [15:0] tick_inc;
    logic        sec_done;
    logic [23:0] time_adv;
    logic        c_s0;
    logic        c_s1;
    logic        c_m0;
    logic        c_m1;
    logic        valid_in;
    logic [7:0]  min_sum;
    logic [1:0]  hr_carry;
    logic [7:0]  min_rem;
    logic [4:0]  hr_sum;
    logic [4:0]  hr_wrap;
    logic        ok;
    logic        ev;

    assign tick_inc = cur.tick_count + 16'd1;
    assign sec_done = (tick_inc >= ticks_per_second);
    assign valid_in = bcd_valid(item.time_value);

    // one-second BCD increment of a valid time
    always_comb
    begin
        time_adv = cur.time_now;
        c_s0 = (cur.time_now[3:0] == 4'd9);
        c_s1 = c_s0 && (cur.time_now[7:4] == 4'd5);
        c_m0 = c_s1 && (cur.time_now[11:8] == 4'd9);
        c_m1 = c_m0 && (cur.time_now[15:12] == 4'd5);
        time_adv[3:0] = c_s0 ? 4'd0 : cur.time_now[3:0] + 4'd1;
        if (c_s0)
            time_adv[7:4] = c_s1 ? 4'd0 : cur.time_now[7:4] + 4'd1;
        if (c_s1)
            time_adv[11:8] = c_m0 ? 4'd0 : cur.time_now[11:8] + 4'd1;
        if (c_m0)
            time_adv[15:12] = c_m1 ? 4'd0 : cur.time_now[15:12] + 4'd1;
        if (c_m1)
        begin
            if (cur.time_now[23:20] == 4'd2 && cur.time_now[19:16] == 4'd3)
                time_adv[23:16] = 8'h00;
            else if (cur.time_now[19:16] == 4'd9)
                time_adv[23:16] = {cur.time_now[23:20] + 4'd1, 4'd0};
            else
                time_adv[19:16] = cur.time_now[19:16] + 4'd1;
        end
    end

    // snooze: minutes in binary, carry whole hours, wrap at a day
    always_comb
    begin
        min_sum = 8'(cur.alarm_at[15:12]) * 8'd10 + 8'(cur.alarm_at[11:8])
                + 8'(item.snooze_minutes);
        if (min_sum >= 8'd180)
        begin
            hr_carry = 2'd3;
            min_rem  = min_sum - 8'd180;
        end
        else if (min_sum >= 8'd120)
        begin
            hr_carry = 2'd2;
            min_rem  = min_sum - 8'd120;
        end
        else if (min_sum >= 8'd60)
        begin
            hr_carry = 2'd1;
            min_rem  = min_sum - 8'd60;
        end
        else
        begin
            hr_carry = 2'd0;
            min_rem  = min_sum;
        end
        hr_sum  = 5'(cur.alarm_at[23:20]) * 5'd10 + 5'(cur.alarm_at[19:16])
                + 5'(hr_carry);
        hr_wrap = (hr_sum >= 5'd24) ? hr_sum - 5'd24 : hr_sum;
    end

    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        ev  = 1'b0;
        case (item.operation)
            OP_TICK:
            begin
                nxt.tick_count = tick_inc;
                if (sec_done)
                begin
                    nxt.tick_count = 16'd0;
                    nxt.time_now   = time_adv;
                    ok             = 1'b1;
                    if (cur.time_now == LAST_SECOND)
                        nxt.armed = 1'b1;
                    if (cur.enabled && nxt.armed && !cur.ringing
                        && time_adv == cur.alarm_at)
                    begin
                        nxt.ringing = 1'b1;
                        ev          = 1'b1;
                    end
                end
            end
            OP_SET_TIME:
            begin
                nxt.time_ok = valid_in;
                ok          = valid_in;
                if (valid_in)
                    nxt.time_now = item.time_value;
            end
            OP_SET_ALRM:
            begin
                nxt.alarm_ok = valid_in;
                nxt.enabled  = valid_in;
                nxt.armed    = valid_in;
                ok           = valid_in;
                if (valid_in)
                    nxt.alarm_at = item.time_value;
            end
            OP_CANCEL:
            begin
                nxt.armed   = 1'b0;
                nxt.ringing = 1'b0;
            end
            OP_DISABLE:
            begin
                nxt.enabled = 1'b0;
                nxt.ringing = 1'b0;
            end
            OP_ENABLE:
            begin
                nxt.enabled = 1'b1;
            end
            OP_SNOOZE:
            begin
                if (cur.armed && cur.enabled)
                begin
                    nxt.ringing  = 1'b0;
                    nxt.alarm_at = {bin_to_bcd({1'b0, hr_wrap}),
                                    bin_to_bcd(min_rem[5:0]),
                                    cur.alarm_at[7:0]};
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.op_ok         = ok;
        res.current_time  = nxt.time_now;
        res.alarm_time    = nxt.alarm_at;
        res.time_valid    = nxt.time_ok;
        res.alarm_valid   = nxt.alarm_ok;
        res.alarm_active  = nxt.armed;
        res.alarm_enabled = nxt.enabled;
        res.alarm_ringing = nxt.ringing;
        res.ring_event    = ev;
    end

endmodule

[verif/alarm_clock_tb_pkg.sv]
// ----------------------------------------------------------------------------
// alarm_clock_tb_pkg
// Status predictor and scoreboard for the BCD alarm clock testbench.
// ----------------------------------------------------------------------------
package alarm_clock_tb_pkg;

    import bcdc_pkg::*;

    // binary hours, minutes, seconds to six BCD digits
    function automatic logic [23:0] hms_to_bcd(input int unsigned h, input int unsigned m,
                                               input int unsigned s);
        logic [23:0] v;
        v[23:20] = 4'(h / 10);
        v[19:16] = 4'(h % 10);
        v[15:12] = 4'(m / 10);
        v[11:8]  = 4'(m % 10);
        v[7:4]   = 4'(s / 10);
        v[3:0]   = 4'(s % 10);
        return v;
    endfunction

    class alarm_clock_predictor;

        logic [15:0] ticks_per_sec;
        logic [15:0] tick_cnt;
        logic [23:0] now_bcd;
        logic [23:0] alarm_bcd;
        bit          time_ok;
        bit          alarm_ok;
        bit          armed;
        bit          enabled;
        bit          ringing;
        result_t     expected_status[$];
        int unsigned errors;

        function new();
            ticks_per_sec = TICKS_RESET;
            tick_cnt      = '0;
            now_bcd       = '0;
            alarm_bcd     = '0;
            time_ok       = 1'b0;
            alarm_ok      = 1'b0;
            armed         = 1'b0;
            enabled       = 1'b0;
            ringing       = 1'b0;
            errors        = 0;
        endfunction

        function void set_ticks(input logic [15:0] v);
            ticks_per_sec = v;
        endfunction

        function int unsigned pending();
            return expected_status.size();
        endfunction

        static function bit hms_ok(input logic [23:0] v);
            if (v[23:20] > 2 || v[19:16] > 9) return 1'b0;
            if (v[23:20] == 2 && v[19:16] > 3) return 1'b0;
            if (v[15:12] > 5 || v[11:8] > 9 || v[7:4] > 5 || v[3:0] > 9) return 1'b0;
            return 1'b1;
        endfunction

        // work out the status that one accepted command beat must produce
        function void note_beat(input item_t it);
            result_t     r;
            int unsigned h;
            int unsigned m;
            int unsigned s;
            bit          ok;
            bit          ring;
            ok   = 1'b0;
            ring = 1'b0;
            case (it.operation)
                OP_TICK:
                begin
                    tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= ticks_per_sec)
                    begin
                        tick_cnt = '0;
                        // leaving the last second of the day re-arms the alarm
                        if (now_bcd == LAST_SECOND) armed = 1'b1;
                        h = now_bcd[23:20] * 10 + now_bcd[19:16];
                        m = now_bcd[15:12] * 10 + now_bcd[11:8];
                        s = now_bcd[7:4] * 10 + now_bcd[3:0] + 1;
                        if (s >= 60)
                        begin
                            s = 0;
                            m = m + 1;
                            if (m >= 60)
                            begin
                                m = 0;
                                h = (h + 1) % 24;
                            end
                        end
                        now_bcd = hms_to_bcd(h, m, s);
                        ok = 1'b1;
                        if (enabled && armed && !ringing && now_bcd == alarm_bcd)
                        begin
                            ringing = 1'b1;
                            ring    = 1'b1;
                        end
                    end
                end
                OP_SET_TIME:
                begin
                    time_ok = hms_ok(it.time_value);
                    if (time_ok) now_bcd = it.time_value;
                    ok = time_ok;
                end
                OP_SET_ALRM:
                begin
                    alarm_ok = hms_ok(it.time_value);
                    enabled  = alarm_ok;
                    armed    = alarm_ok;
                    if (alarm_ok) alarm_bcd = it.time_value;
                    ok = alarm_ok;
                end
                OP_CANCEL:
                begin
                    armed   = 1'b0;
                    ringing = 1'b0;
                end
                OP_DISABLE:
                begin
                    enabled = 1'b0;
                    ringing = 1'b0;
                end
                OP_ENABLE:
                    enabled = 1'b1;
                OP_SNOOZE:
                begin
                    if (armed && enabled)
                    begin
                        ringing = 1'b0;
                        h = alarm_bcd[23:20] * 10 + alarm_bcd[19:16];
                        m = alarm_bcd[15:12] * 10 + alarm_bcd[11:8] + it.snooze_minutes;
                        s = alarm_bcd[7:4] * 10 + alarm_bcd[3:0];
                        h = (h + m / 60) % 24;
                        m = m % 60;
                        alarm_bcd = hms_to_bcd(h, m, s);
                    end
                end
                default:
                    ;
            endcase
            r.op_ok         = ok;
            r.current_time  = now_bcd;
            r.alarm_time    = alarm_bcd;
            r.time_valid    = time_ok;
            r.alarm_valid   = alarm_ok;
            r.alarm_active  = armed;
            r.alarm_enabled = enabled;
            r.alarm_ringing = ringing;
            r.ring_event    = ring;
            expected_status.push_back(r);
        endfunction

        function void compare(input string name, input logic [23:0] exp_v,
                              input logic [23:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s: expected %h, got %h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_beat(input result_t got);
            result_t exp_r;
            if (expected_status.size() == 0)
            begin
                $error("status beat with nothing outstanding: %h", got);
                errors++;
                return;
            end
            exp_r = expected_status.pop_front();
            compare("op_ok", exp_r.op_ok, got.op_ok);
            compare("current_time", exp_r.current_time, got.current_time);
            compare("alarm_time", exp_r.alarm_time, got.alarm_time);
            compare("time_valid", exp_r.time_valid, got.time_valid);
            compare("alarm_valid", exp_r.alarm_valid, got.alarm_valid);
            compare("alarm_active", exp_r.alarm_active, got.alarm_active);
            compare("alarm_enabled", exp_r.alarm_enabled, got.alarm_enabled);
            compare("alarm_ringing", exp_r.alarm_ringing, got.alarm_ringing);
            compare("ring_event", exp_r.ring_event, got.ring_event);
        endfunction

    endclass

endpackage

[verif/tb_bcd_clock_with_alarm_snooze_unit.sv]
// ----------------------------------------------------------------------------
// tb_bcd_clock_with_alarm_snooze_unit
// Drives directed and random command beats into the BCD alarm clock at
// several prescaler settings and checks every status beat against a
// predictor, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bcd_clock_with_alarm_snooze_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import bcdc_pkg::*;
    import alarm_clock_tb_pkg::*;

    localparam logic [2:0] REG_TICKS_PER_SEC = 3'd0;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alarm_clock_predictor status_check = new();

    int unsigned burst_left;
    int unsigned stall_mode;
    int unsigned stall_left;
    int unsigned stall_phase;

    bcd_clock_with_alarm_snooze_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // check accepted status beats, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready) status_check.check_beat(result);
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= (stall_phase % 5) >= 3;
            default: result_ready <= (stall_phase % 11) == 0;
        endcase
    end

    function automatic item_t mk(input op_t op, input logic [23:0] tv, input logic [6:0] sm);
        item_t it;
        it.operation      = op;
        it.time_value     = tv;
        it.snooze_minutes = sm;
        return it;
    endfunction

    task automatic send_beat(input item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        status_check.note_beat(it);
        burst_left--;
    endtask

    // hold off until every outstanding status beat has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (status_check.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_ticks(input logic [15:0] v);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TICKS_PER_SEC;
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        status_check.set_ticks(v);
        // read back straight after
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== v)
        begin
            $error("ticks_per_second readback: expected %h, got %h", v, prdata[15:0]);
            status_check.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned cnt;
        int unsigned h;
        int unsigned m;
        int unsigned s;
        int unsigned secs;
        int unsigned len;
        int unsigned r;
        item_t       it;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                it = mk(op_t'($urandom_range(0, 7)), 24'($urandom), 7'($urandom));
                send_beat(it);
                cnt++;
            end
            else
            begin
                // set a time, an alarm a few seconds on, then mostly ticks
                h = $urandom_range(0, 23);
                m = $urandom_range(0, 59);
                s = $urandom_range(0, 59);
                if ($urandom_range(0, 2) == 0)
                begin
                    h = 23;
                    m = 59;
                    s = $urandom_range(45, 59);
                end
                send_beat(mk(OP_SET_TIME, hms_to_bcd(h, m, s), 7'd0));
                secs = (h * 3600 + m * 60 + s + $urandom_range(0, 12)) % 86400;
                send_beat(mk(OP_SET_ALRM, hms_to_bcd(secs / 3600, (secs / 60) % 60, secs % 60),
                             7'd0));
                len = $urandom_range(10, 60);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        it = mk(OP_TICK, 24'($urandom), 7'($urandom));
                    else if (r < 74)
                        it = mk(OP_SNOOZE, 24'($urandom), ($urandom_range(0, 3) == 0) ?
                                7'($urandom) : 7'($urandom_range(0, 2)));
                    else if (r < 78)
                        it = mk(OP_CANCEL, 24'($urandom), 7'($urandom));
                    else if (r < 82)
                        it = mk(OP_DISABLE, 24'($urandom), 7'($urandom));
                    else if (r < 88)
                        it = mk(OP_ENABLE, 24'($urandom), 7'($urandom));
                    else if (r < 92)
                        it = mk(OP_READ, 24'($urandom), 7'($urandom));
                    else if (r < 96)
                        it = mk(OP_SET_ALRM, hms_to_bcd($urandom_range(0, 23),
                                $urandom_range(0, 59), $urandom_range(0, 59)), 7'd0);
                    else
                        it = mk(($urandom_range(0, 1) == 0) ? OP_SET_TIME : OP_SET_ALRM,
                                24'($urandom), 7'($urandom));
                    send_beat(it);
                end
                cnt += len + 2;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset prescaler: ticks count but no second elapses
        send_beat(mk(OP_READ, 24'h000000, 7'd0));
        send_beat(mk(OP_TICK, 24'hFFFFFF, 7'h7F));
        send_beat(mk(OP_TICK, 24'h000000, 7'h00));
        write_ticks(16'd1);
        // clock runs before it has been set
        send_beat(mk(OP_TICK, 24'h0, 7'd0));
        send_beat(mk(OP_TICK, 24'h0, 7'd0));
        // bad digits in hour, minute and second positions
        send_beat(mk(OP_SET_TIME, 24'h300000, 7'd0));
        send_beat(mk(OP_SET_TIME, 24'h240000, 7'd0));
        send_beat(mk(OP_SET_TIME, 24'h0A0000, 7'd0));
        send_beat(mk(OP_SET_TIME, 24'h006000, 7'd0));
        send_beat(mk(OP_SET_TIME, 24'h00000A, 7'd0));
        send_beat(mk(OP_SET_TIME, 24'hFFFFFF, 7'd0));
        // cancelled alarm re-armed by midnight, then rings
        send_beat(mk(OP_SET_TIME, 24'h235958, 7'd0));
        send_beat(mk(OP_SET_ALRM, 24'h240000, 7'd0));
        send_beat(mk(OP_SET_ALRM, 24'h000000, 7'd0));
        send_beat(mk(OP_CANCEL, 24'h0, 7'd0));
        send_beat(mk(OP_TICK, 24'h0, 7'd0));
        send_beat(mk(OP_TICK, 24'h0, 7'd0));
        send_beat(mk(OP_TICK, 24'h0, 7'd0));
        // re-setting the alarm leaves it ringing; snooze silences it
        send_beat(mk(OP_SET_ALRM, 24'h000000, 7'd0));
        send_beat(mk(OP_SNOOZE, 24'h0, 7'd127));
        // snooze across midnight
        send_beat(mk(OP_SET_ALRM, 24'h235930, 7'd0));
        send_beat(mk(OP_SNOOZE, 24'h0, 7'd127));
        send_beat(mk(OP_CANCEL, 24'h0, 7'd0));
        send_beat(mk(OP_SNOOZE, 24'h0, 7'd5));
        send_beat(mk(OP_ENABLE, 24'h0, 7'd0));
        send_beat(mk(OP_DISABLE, 24'h0, 7'd0));
        send_beat(mk(OP_READ, 24'h0, 7'd0));

        write_ticks(16'd2);
        run_random(230);
        write_ticks(16'd0);
        run_random(230);
        write_ticks(16'hFFFF);
        run_random(50);
        // lowered below the running count: next tick completes a second
        write_ticks(16'd4);
        run_random(150);
        write_ticks(16'd3);
        run_random(200);
        write_ticks(TICKS_RESET);
        run_random(40);
        write_ticks(16'd1);
        run_random(380);

        wait_drained();
        repeat (10) @(posedge clk);
        if (status_check.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
src/bcdc_pkg.sv
src/bcdc_step.sv
src/bcd_clock_with_alarm_snooze_unit.sv
verif/alarm_clock_tb_pkg.sv
verif/tb_bcd_clock_with_alarm_snooze_unit.sv
